### rtl/utf_pkg.sv
`default_nettype none
package utf_pkg;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  localparam logic [5:0] HIGH_TAG = 6'b110110;
  localparam logic [5:0] LOW_TAG  = 6'b110111;

  // Work for one request: up to four UTF-8 bytes, then an optional status.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n_data;
    logic            has_status;
    logic            status_err;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_ctrl_t;

endpackage
`default_nettype wire

### rtl/utf_front.sv
`default_nettype none
module utf_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [15:0]     s_tdata,   // code_unit
  input  wire logic            s_tlast,   // last_unit
  input  wire logic            q_full,
  output logic                 q_push,
  output utf_pkg::entry_t      q_entry
);

  logic [9:0] pending_high;
  logic       have_pending;
  logic       stopped;
  logic       error_seen;

  logic [9:0] pending_high_next;
  logic       have_pending_next;
  logic       stopped_next;
  logic       error_seen_next;

  logic        accept;
  logic        is_high;
  logic        is_low;
  logic [15:0] u;
  logic [10:0] plane;
  logic [20:0] cp;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign u        = s_tdata;
  assign is_high  = u[15:10] == utf_pkg::HIGH_TAG;
  assign is_low   = u[15:10] == utf_pkg::LOW_TAG;
  // 0x10000 + (high << 10) + low bits, with the plane in the upper bits.
  assign plane    = {1'b0, pending_high} + 11'h040;
  assign cp       = {plane[10:0], u[9:0]};

  always_comb begin
    pending_high_next = pending_high;
    have_pending_next = have_pending;
    stopped_next      = stopped;
    error_seen_next   = error_seen;
    q_entry           = '0;

    if (!stopped) begin
      if (have_pending) begin
        have_pending_next = 1'b0;
        pending_high_next = '0;
        if (is_low) begin
          q_entry.n_data   = 3'd4;
          q_entry.bytes[0] = {5'b11110, cp[20:18]};
          q_entry.bytes[1] = {2'b10, cp[17:12]};
          q_entry.bytes[2] = {2'b10, cp[11:6]};
          q_entry.bytes[3] = {2'b10, cp[5:0]};
        end else begin
          error_seen_next = 1'b1;
          stopped_next    = 1'b1;
        end
      end else if (u == 16'd0) begin
        stopped_next = 1'b1;
      end else if (is_high) begin
        if (s_tlast) begin
          error_seen_next = 1'b1;
          stopped_next    = 1'b1;
        end else begin
          pending_high_next = u[9:0];
          have_pending_next = 1'b1;
        end
      end else if (is_low) begin
        error_seen_next = 1'b1;
        stopped_next    = 1'b1;
      end else if (u[15:7] == 9'd0) begin
        q_entry.n_data   = 3'd1;
        q_entry.bytes[0] = u[7:0];
      end else if (u[15:11] == 5'd0) begin
        q_entry.n_data   = 3'd2;
        q_entry.bytes[0] = {3'b110, u[10:6]};
        q_entry.bytes[1] = {2'b10, u[5:0]};
      end else begin
        q_entry.n_data   = 3'd3;
        q_entry.bytes[0] = {4'b1110, u[15:12]};
        q_entry.bytes[1] = {2'b10, u[11:6]};
        q_entry.bytes[2] = {2'b10, u[5:0]};
      end
    end

    q_entry.has_status = s_tlast;
    q_entry.status_err = error_seen_next;

    // The closing unit starts the next string from a clean state.
    if (s_tlast) begin
      pending_high_next = '0;
      have_pending_next = 1'b0;
      stopped_next      = 1'b0;
      error_seen_next   = 1'b0;
    end
  end

  // Units that produce no result are not queued.
  assign q_push = accept && (q_entry.has_status || (q_entry.n_data != 3'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_high <= '0;
      have_pending <= 1'b0;
      stopped      <= 1'b0;
      error_seen   <= 1'b0;
    end else if (accept) begin
      pending_high <= pending_high_next;
      have_pending <= have_pending_next;
      stopped      <= stopped_next;
      error_seen   <= error_seen_next;
    end
  end

endmodule
`default_nettype wire

### rtl/utf_queue.sv
`default_nettype none
module utf_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire utf_pkg::entry_t wr_entry,
  input  wire logic            pop,
  output utf_pkg::entry_t      rd_entry,
  output utf_pkg::q_ctrl_t     ctrl
);

  utf_pkg::entry_t             slots [utf_pkg::QDepth];
  logic [utf_pkg::QPtrW-1:0]   wr_ptr;
  logic [utf_pkg::QPtrW-1:0]   rd_ptr;
  logic [utf_pkg::QPtrW:0]     count;
  logic                        do_push;
  logic                        do_pop;

  assign ctrl.full  = count == (utf_pkg::QPtrW + 1)'(utf_pkg::QDepth);
  assign ctrl.empty = count == '0;
  assign do_push    = push && !ctrl.full;
  assign do_pop     = pop && !ctrl.empty;
  assign rd_entry   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/utf_back.sv
`default_nettype none
module utf_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire utf_pkg::entry_t  head,
  input  wire utf_pkg::q_ctrl_t q_ctrl,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [7:0]            m_tdata,  // out_byte
  output logic [1:0]            m_tuser,  // kind
  output logic                  m_tlast   // last_of_item
);

  utf_pkg::entry_t cur;
  logic            cur_valid;
  logic [2:0]      idx;

  logic       out_load;
  logic       adv;
  logic       fin;
  logic [2:0] total;
  logic       is_data;
  logic [7:0] elem_byte;
  logic [1:0] elem_kind;

  assign total    = cur.n_data + {2'b00, cur.has_status};
  assign out_load = !m_tvalid || m_tready;
  assign adv      = out_load && cur_valid;
  assign fin      = adv && (idx == total - 3'd1);
  assign q_pop    = !q_ctrl.empty && (!cur_valid || fin);
  assign is_data  = idx < cur.n_data;

  always_comb begin
    if (is_data) begin
      elem_byte = cur.bytes[idx[1:0]];
      elem_kind = utf_pkg::KIND_DATA;
    end else begin
      elem_byte = 8'd0;
      elem_kind = cur.status_err ? utf_pkg::KIND_ERR : utf_pkg::KIND_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= head;
    end
    if (out_load) begin
      m_tdata <= elem_byte;
      m_tuser <= elem_kind;
      m_tlast <= idx == total - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= cur_valid;
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (fin) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else if (adv) begin
        idx <= idx + 3'd1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder.
// Input stream (s_*): one UTF-16 code unit per request in s_tdata, s_tlast on
// the final unit of a string. Output stream (m_*): one UTF-8 byte per request
// in m_tdata with m_tuser = 0, and on the final unit a status request with
// m_tuser = 1 (ok) or 2 (error) and m_tdata = 0. m_tlast marks the last
// output request caused by one input unit.
// A unit is classified and encoded in the cycle it is accepted and queued;
// the serializer then loads it and registers each output once m_* is free.
// Throughput: one unit per cycle for ASCII text while m_tready is high; a unit
// producing N results holds the byte-wide output for N bytes, and a 4-entry
// queue between the encoder and the byte serializer absorbs short bursts.
// s_tready drops only while that queue is full, so a stalled receiver holds
// m_* steady and back-pressures the input once the queue fills.
// Reset clears the surrogate, stop and error state, empties the queue and
// drops m_tvalid. After an error status the receiver discards that string.
`default_nettype none
module utf16_to_utf8_transcoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // code_unit
  input  wire logic        s_tlast,   // last_unit
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // out_byte
  output logic [1:0]       m_tuser,   // kind
  output logic             m_tlast    // last_of_item
);

  utf_pkg::entry_t  wr_entry;
  utf_pkg::entry_t  head;
  utf_pkg::q_ctrl_t q_ctrl;
  logic             push;
  logic             pop;

  utf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_ctrl.full),
    .q_push   (push),
    .q_entry  (wr_entry)
  );

  utf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (head),
    .ctrl     (q_ctrl)
  );

  utf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_ctrl   (q_ctrl),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

### dv/utf8_stream_checker.sv
module utf8_stream_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // code_unit
  input  logic        s_tlast,   // last_unit
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // out_byte
  input  logic [1:0]  m_tuser,   // kind
  input  logic        m_tlast,   // last_of_item
  output int          fail_count,
  output int          outstanding,
  output int          data_bytes,
  output int          ok_strings,
  output int          err_strings
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       tail;
  } utf8_result_t;

  utf8_result_t expected_results[$];

  // Predicted transcoder state.
  logic [9:0] held_high;
  logic       high_held;
  logic       halted;
  logic       failed;

  task automatic add_result(input logic [7:0] data, input logic [1:0] kind);
    utf8_result_t item;
    item = '{data: data, kind: kind, tail: 1'b0};
    expected_results.insert(expected_results.size(), item);
  endtask

  task automatic add_codepoint(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_result(cp[7:0], utf_pkg::KIND_DATA);
    end else if (cp < 21'h800) begin
      add_result({3'b110, cp[10:6]}, utf_pkg::KIND_DATA);
      add_result({2'b10, cp[5:0]}, utf_pkg::KIND_DATA);
    end else if (cp < 21'h10000) begin
      add_result({4'b1110, cp[15:12]}, utf_pkg::KIND_DATA);
      add_result({2'b10, cp[11:6]}, utf_pkg::KIND_DATA);
      add_result({2'b10, cp[5:0]}, utf_pkg::KIND_DATA);
    end else begin
      add_result({5'b11110, cp[20:18]}, utf_pkg::KIND_DATA);
      add_result({2'b10, cp[17:12]}, utf_pkg::KIND_DATA);
      add_result({2'b10, cp[11:6]}, utf_pkg::KIND_DATA);
      add_result({2'b10, cp[5:0]}, utf_pkg::KIND_DATA);
    end
  endtask

  task automatic transcode_unit(input logic [15:0] unit, input logic is_last);
    logic         is_high;
    logic         is_low;
    int           first_idx;
    int           last_idx;
    utf8_result_t closing;
    is_high = (unit[15:10] == utf_pkg::HIGH_TAG);
    is_low = (unit[15:10] == utf_pkg::LOW_TAG);
    first_idx = expected_results.size();
    if (!halted) begin
      if (high_held) begin
        // Whatever follows a held high surrogate is consumed by the pairing attempt.
        high_held = 1'b0;
        if (is_low) begin
          add_codepoint(21'h10000 + {held_high, unit[9:0]});
        end else begin
          failed = 1'b1;
          halted = 1'b1;
        end
        held_high = '0;
      end else if (unit == 16'h0000) begin
        halted = 1'b1;
      end else if (is_high) begin
        if (is_last) begin
          failed = 1'b1;
          halted = 1'b1;
        end else begin
          held_high = unit[9:0];
          high_held = 1'b1;
        end
      end else if (is_low) begin
        failed = 1'b1;
        halted = 1'b1;
      end else begin
        add_codepoint({5'd0, unit});
      end
    end
    if (is_last) begin
      add_result(8'h00, failed ? utf_pkg::KIND_ERR : utf_pkg::KIND_OK);
      held_high = '0;
      high_held = 1'b0;
      halted = 1'b0;
      failed = 1'b0;
    end
    if (expected_results.size() > first_idx) begin
      last_idx = expected_results.size() - 1;
      closing = expected_results[last_idx];
      closing.tail = 1'b1;
      expected_results[last_idx] = closing;
    end
  endtask

  always @(posedge clk) begin
    utf8_result_t want;
    if (rst) begin
      expected_results.delete();
      held_high = '0;
      high_held = 1'b0;
      halted = 1'b0;
      failed = 1'b0;
      fail_count = 0;
      data_bytes = 0;
      ok_strings = 0;
      err_strings = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: out_byte %02h kind %0d last_of_item %0b",
                 m_tdata, m_tuser, m_tlast);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (m_tdata !== want.data) begin
            $error("out_byte mismatch: expected %02h, actual %02h", want.data, m_tdata);
            fail_count++;
          end
          if (m_tuser !== want.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", want.kind, m_tuser);
            fail_count++;
          end
          if (m_tlast !== want.tail) begin
            $error("last_of_item mismatch: expected %0b, actual %0b", want.tail, m_tlast);
            fail_count++;
          end
          case (want.kind)
            utf_pkg::KIND_DATA: data_bytes++;
            utf_pkg::KIND_OK:   ok_strings++;
            default:            err_strings++;
          endcase
        end
      end
      if (s_tvalid && s_tready) begin
        transcode_unit(s_tdata, s_tlast);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

### dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  int fail_count;
  int outstanding;
  int data_bytes;
  int ok_strings;
  int err_strings;

  int send_idle = 17;
  int recv_idle = 69;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int units_sent = 0;
  int strings_sent = 0;

  logic [15:0] string_units[$];

  utf16_to_utf8_transcoder uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  utf8_stream_checker stream_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .data_bytes  (data_bytes),
    .ok_strings  (ok_strings),
    .err_strings (err_strings)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Output side: random backpressure, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= 250;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_unit(input logic [15:0] unit, input logic is_last);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= unit;
    s_tlast <= is_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    units_sent++;
    if (is_last) strings_sent++;
  endtask

  task automatic append_unit(input int value);
    string_units.insert(string_units.size(), 16'(value));
  endtask

  task automatic send_random_string(input bit clean);
    int n_points;
    int k;
    int pick;
    n_points = $urandom_range(1, 6);
    string_units.delete();
    for (k = 0; k < n_points; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        append_unit($urandom_range(1, 16'h007F));
      end else if (pick < 50) begin
        append_unit($urandom_range(16'h0080, 16'h07FF));
      end else if (pick < 72) begin
        if ($urandom_range(0, 1) == 0) append_unit($urandom_range(16'h0800, 16'hD7FF));
        else append_unit($urandom_range(16'hE000, 16'hFFFF));
      end else if (pick < 90 || clean) begin
        append_unit($urandom_range(16'hD800, 16'hDBFF));
        append_unit($urandom_range(16'hDC00, 16'hDFFF));
      end else begin
        // Broken content: terminator, stray surrogates or any unit at all.
        case ($urandom_range(0, 3))
          0:       append_unit(16'h0000);
          1:       append_unit($urandom_range(16'hDC00, 16'hDFFF));
          2:       append_unit($urandom_range(16'hD800, 16'hDBFF));
          default: append_unit($urandom_range(0, 16'hFFFF));
        endcase
      end
    end
    for (k = 0; k < string_units.size(); k++) begin
      send_unit(string_units[k], k == string_units.size() - 1);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Encoding length boundaries and the full code unit range.
    send_unit(16'h0001, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    // Lowest and highest supplementary code points.
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    // A lone low surrogate stops the string.
    send_unit(16'hDC00, 1'b0);
    send_unit(16'h0041, 1'b1);
    // A high surrogate followed by a non-surrogate, then by a zero unit.
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0041, 1'b1);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'h0000, 1'b1);
    // A high surrogate closing the string.
    send_unit(16'hD800, 1'b1);
    // A zero unit ends conversion; the rest is ignored but the status stays ok.
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0000, 1'b0);
    send_unit(16'h0042, 1'b1);
    send_unit(16'h0000, 1'b1);
    send_unit(16'hDFFF, 1'b1);

    repeat (10) send_random_string($urandom_range(0, 99) < 80);
    // The output side stalls for a long time while input keeps coming.
    hold_requests <= hold_requests + 1;
    while (units_sent < 150) send_random_string($urandom_range(0, 99) < 80);
    drain_results();

    send_idle = 69;
    recv_idle <= 17;
    while (units_sent < 310) send_random_string($urandom_range(0, 99) < 80);
    drain_results();

    send_idle = 0;
    recv_idle <= 0;
    while (units_sent < 428) send_random_string($urandom_range(0, 99) < 80);
    drain_results();
    repeat (12) @(negedge clk);

    $display("Covered %0d code units in %0d strings under three backpressure mixes.",
             units_sent, strings_sent);
    $display("Checked %0d UTF-8 bytes, %0d clean and %0d failed string statuses.",
             data_bytes, ok_strings, err_strings);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

### files.f
rtl/utf_pkg.sv
rtl/utf_front.sv
rtl/utf_queue.sv
rtl/utf_back.sv
rtl/utf16_to_utf8_transcoder.sv
dv/utf8_stream_checker.sv
dv/tb.sv
